[rtl/core/hrsid_pkg.sv]
package hrsid_pkg;

    // frame layout
    localparam logic [3:0] LAST_POS  = 4'd13;
    localparam logic [3:0] MODE_BYTE = 4'd4;
    localparam logic [7:0] MODE_MASK = 8'h30;

    // field sizes and decision thresholds
    localparam logic [6:0] SID_FIELD_BITS  = 7'd79;
    localparam logic [6:0] CLASS1_BITS     = 7'd62;
    localparam logic [6:0] C1_ZEROS_LIMIT  = 7'd3;
    localparam logic [6:0] SID_THR_BCI     = 7'd16;
    localparam logic [6:0] SID_THR_NO_BCI  = 7'd11;
    localparam logic [6:0] UPGRADE_LO      = 7'd16;
    localparam logic [6:0] UPGRADE_HI      = 7'd25;

    // configuration register map (word index)
    localparam logic REG_BFI_UPGRADE_EN = 1'b0;

    typedef enum logic [1:0] {
        SID_VALID   = 2'd0,
        SID_INVALID = 2'd1,
        SID_SPEECH  = 2'd2
    } t_sid_class;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
        logic       bad_chan;
    } t_in_item;

    typedef struct packed {
        t_sid_class sid_class;
        logic       bfi_upgrade;
    } t_out_item;

    // counts of a frame picked by its mode
    typedef struct packed {
        logic       voiced;
        logic [6:0] sid_ones;
        logic [4:0] c2_ones;
    } t_frame_sum;

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'd0, v[i]};
        end
        return c;
    endfunction

    function automatic logic [7:0] voiced_sid_mask(input logic [3:0] pos);
        logic [7:0] m;
        case (pos)
            4'd0, 4'd1, 4'd2, 4'd3: m = 8'h00;
            4'd4:                   m = 8'h7F;
            default:                m = (pos <= LAST_POS) ? 8'hFF : 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] unvoiced_sid_mask(input logic [3:0] pos);
        logic [7:0] m;
        case (pos)
            4'd0:    m = 8'h08;
            4'd1:    m = 8'hEF;
            4'd2:    m = 8'h1F;
            4'd3:    m = 8'h3F;
            4'd4:    m = 8'hF3;
            4'd5:    m = 8'hFC;
            4'd6:    m = 8'hA4;
            4'd7:    m = 8'hFF;
            4'd8:    m = 8'hFA;
            4'd9:    m = 8'h3F;
            4'd10:   m = 8'hFF;
            4'd11:   m = 8'h47;
            4'd12:   m = 8'hFF;
            4'd13:   m = 8'hEC;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] voiced_c2_mask(input logic [3:0] pos);
        logic [7:0] m;
        case (pos)
            4'd10:   m = 8'h7F;
            4'd11:   m = 8'h80;
            4'd12:   m = 8'h3F;
            4'd13:   m = 8'hE0;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] unvoiced_c2_mask(input logic [3:0] pos);
        logic [7:0] m;
        case (pos)
            4'd10:   m = 8'h07;
            4'd11:   m = 8'h07;
            4'd12:   m = 8'hFF;
            4'd13:   m = 8'hE0;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

[rtl/core/gsm_hr_sid_frame_classifier_core.sv]
// Half-rate SID frame classifier. Frame bytes enter one per item, byte 0 first,
// and the block takes one byte per clock cycle without gaps between frames
// unless the input side stalls. A byte is held in the input register; the
// popcount accumulation and the classification sit between that register and
// the result register, so the last byte of a frame passes both registers before
// its result item is valid. Only the last byte of a frame (position 13) yields
// a result item. The input side stalls only when a last byte meets a result
// that is still stalled at the output. frame_start restarts the byte position
// at any byte; without it frames follow each other every 14 bytes. bad_chan,
// the bad channel indication, is taken from the last byte. The one register,
// bfi_upgrade_enable (bit 0 at address 0, reset 1), gates the BCI to BFI upgrade
// flag; the user must write it only while idle. The block does not enforce this.
module gsm_hr_sid_frame_classifier_core
    import hrsid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       r_bfi_upgrade_enable;
    logic       in_accept;
    logic       out_free;
    logic       step;
    logic       last;
    t_frame_sum sum;
    t_out_item  result;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BFI_UPGRADE_EN) ? {31'd0, r_bfi_upgrade_enable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bfi_upgrade_enable <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_BFI_UPGRADE_EN)) begin
            r_bfi_upgrade_enable <= pwdata[0];
        end
    end

    // flow control between input register and result register
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && (!last || out_free);
    assign o_in_stall = r_in_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_item;
        end
    end

    hrsid_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .o_last  (last),
        .o_sum   (sum)
    );

    hrsid_decide u_decide (
        .i_sum        (sum),
        .i_bci        (r_in.bad_chan),
        .i_upgrade_en (r_bfi_upgrade_enable),
        .o_item       (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && last) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // a new result needs a byte in the input register the cycle before
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(r_in_valid))
        else $error("result appeared without a byte");

    // an output freed by the consumer holds no stale result unless reloaded
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !(step && last)) |=> !r_out_valid)
        else $error("result repeated");
`endif

endmodule

[rtl/core/hrsid_accum.sv]
module hrsid_accum
    import hrsid_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    output logic       o_last,
    output t_frame_sum o_sum
);

    logic [3:0] r_pos, n_pos;
    logic       r_voiced, n_voiced;
    logic [6:0] r_v_sid, n_v_sid;
    logic [6:0] r_u_sid, n_u_sid;
    logic [4:0] r_v_c2, n_v_c2;
    logic [4:0] r_u_c2, n_u_c2;
    logic [3:0] pos;
    logic       clr;
    logic [7:0] b;

    // byte position, restart on frame_start
    always_comb begin
        pos = i_item.frame_start ? 4'd0 : r_pos;
        if (pos > LAST_POS) begin
            pos = 4'd0;
        end
    end

    assign clr = (pos == 4'd0);
    assign b   = i_item.frame_byte;

    // masked popcounts added to the running counts of both layouts
    always_comb begin
        n_v_sid = (clr ? 7'd0 : r_v_sid) + {3'd0, pop8(b & voiced_sid_mask(pos))};
        n_u_sid = (clr ? 7'd0 : r_u_sid) + {3'd0, pop8(b & unvoiced_sid_mask(pos))};
        n_v_c2  = (clr ? 5'd0 : r_v_c2) + {1'b0, pop8(b & voiced_c2_mask(pos))};
        n_u_c2  = (clr ? 5'd0 : r_u_c2) + {1'b0, pop8(b & unvoiced_c2_mask(pos))};
        if (pos == MODE_BYTE) begin
            n_voiced = |(b & MODE_MASK);
        end else begin
            n_voiced = clr ? 1'b0 : r_voiced;
        end
        n_pos = (pos == LAST_POS) ? 4'd0 : pos + 4'd1;
    end

    // counts for the frame's mode, valid with the last byte
    assign o_last         = (pos == LAST_POS);
    assign o_sum.voiced   = n_voiced;
    assign o_sum.sid_ones = n_voiced ? n_v_sid : n_u_sid;
    assign o_sum.c2_ones  = n_voiced ? n_v_c2 : n_u_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 4'd0;
            r_voiced <= 1'b0;
            r_v_sid  <= 7'd0;
            r_u_sid  <= 7'd0;
            r_v_c2   <= 5'd0;
            r_u_c2   <= 5'd0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_voiced <= n_voiced;
            r_v_sid  <= n_v_sid;
            r_u_sid  <= n_u_sid;
            r_v_c2   <= n_v_c2;
            r_u_c2   <= n_u_c2;
        end
    end

endmodule

[rtl/core/hrsid_decide.sv]
module hrsid_decide
    import hrsid_pkg::*;
(
    input  t_frame_sum i_sum,
    input  logic       i_bci,
    input  logic       i_upgrade_en,
    output t_out_item  o_item
);

    logic [6:0] c2_ext;
    logic [6:0] c1_ones;
    logic [6:0] sid_zeros;
    logic [6:0] c1_zeros;
    logic [6:0] thr;
    t_sid_class cls;

    // zero counts, clamped at zero
    always_comb begin
        c2_ext    = {2'd0, i_sum.c2_ones};
        c1_ones   = (i_sum.sid_ones >= c2_ext) ? i_sum.sid_ones - c2_ext : 7'd0;
        sid_zeros = (i_sum.sid_ones <= SID_FIELD_BITS) ?
                    SID_FIELD_BITS - i_sum.sid_ones : 7'd0;
        c1_zeros  = (c1_ones <= CLASS1_BITS) ? CLASS1_BITS - c1_ones : 7'd0;
    end

    // classification, unvoiced valid sid demoted
    always_comb begin
        thr = i_bci ? SID_THR_BCI : SID_THR_NO_BCI;
        if (c1_zeros < C1_ZEROS_LIMIT) begin
            cls = i_sum.voiced ? SID_VALID : SID_INVALID;
        end else if (sid_zeros < thr) begin
            cls = SID_INVALID;
        end else begin
            cls = SID_SPEECH;
        end
    end

    assign o_item.sid_class   = cls;
    assign o_item.bfi_upgrade = i_bci && i_upgrade_en &&
                                (sid_zeros >= UPGRADE_LO) && (sid_zeros <= UPGRADE_HI);

endmodule

[test/tb_top.sv]
module tb_top;
    import hrsid_pkg::*;

    localparam int FRAME_LEN      = 14;
    localparam int POS_LAST       = 13;
    localparam int RESULT_LATENCY = 2;
    localparam int SETTLE_CYCLES  = RESULT_LATENCY + 4;
    localparam int DRAIN_LIMIT    = 5000;

    // decision constants of the classifier
    localparam int SID_BITS       = 79;
    localparam int C1_BITS        = 62;
    localparam int C1_ZEROS_VALID = 3;
    localparam int THR_BCI        = 16;
    localparam int THR_NO_BCI     = 11;
    localparam int UPG_LO         = 16;
    localparam int UPG_HI         = 25;
    localparam int MODE_BYTE_POS  = 4;

    localparam logic [2:0] ADDR_UPGRADE_EN = 3'(4 * REG_BFI_UPGRADE_EN);
    localparam logic [2:0] ADDR_UNMAPPED   = 3'd4;

    // per-byte masks, byte 0 first
    localparam logic [0:13][7:0] V_SID_MASK = {{4{8'h00}}, 8'h7F, {9{8'hFF}}};
    localparam logic [0:13][7:0] U_SID_MASK = {
        8'h08, 8'hEF, 8'h1F, 8'h3F, 8'hF3, 8'hFC, 8'hA4,
        8'hFF, 8'hFA, 8'h3F, 8'hFF, 8'h47, 8'hFF, 8'hEC};
    localparam logic [0:13][7:0] V_C2_MASK = {{10{8'h00}}, 8'h7F, 8'h80, 8'h3F, 8'hE0};
    localparam logic [0:13][7:0] U_C2_MASK = {{10{8'h00}}, 8'h07, 8'h07, 8'hFF, 8'hE0};

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // classifier state as predicted
    logic [3:0] frame_pos     = '0;
    logic       frame_voiced  = 1'b0;
    logic [6:0] v_sid_ones    = '0;
    logic [6:0] u_sid_ones    = '0;
    logic [4:0] v_c2_ones     = '0;
    logic [4:0] u_c2_ones     = '0;
    logic       upgrade_en    = 1'b1;

    t_out_item  sid_results_q[$];
    logic [7:0] frame_buf [FRAME_LEN];

    int n_errors       = 0;
    int items_sent     = 0;
    int send_gap_pct   = 0;
    int sink_stall_pct = 0;

    gsm_hr_sid_frame_classifier_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    // count one accepted frame byte, classify on the last one
    function automatic void take_frame_byte(input t_in_item it);
        logic [3:0] p;
        int sid_ones, c2_ones, c1_ones, sid_zeros, c1_zeros, thr;
        t_sid_class cls;
        t_out_item res;
        p = it.frame_start ? 4'd0 : frame_pos;
        if (p > POS_LAST) p = 4'd0;
        if (p == 0) begin
            frame_voiced = 1'b0;
            v_sid_ones = '0;
            u_sid_ones = '0;
            v_c2_ones = '0;
            u_c2_ones = '0;
        end
        v_sid_ones = v_sid_ones + 7'($countones(it.frame_byte & V_SID_MASK[p]));
        u_sid_ones = u_sid_ones + 7'($countones(it.frame_byte & U_SID_MASK[p]));
        v_c2_ones = v_c2_ones + 5'($countones(it.frame_byte & V_C2_MASK[p]));
        u_c2_ones = u_c2_ones + 5'($countones(it.frame_byte & U_C2_MASK[p]));
        if (p == MODE_BYTE_POS) frame_voiced = |it.frame_byte[5:4];
        if (p != POS_LAST) begin
            frame_pos = p + 4'd1;
            return;
        end
        frame_pos = 4'd0;

        sid_ones = frame_voiced ? int'(v_sid_ones) : int'(u_sid_ones);
        c2_ones = frame_voiced ? int'(v_c2_ones) : int'(u_c2_ones);
        c1_ones = (sid_ones >= c2_ones) ? sid_ones - c2_ones : 0;
        sid_zeros = (sid_ones <= SID_BITS) ? SID_BITS - sid_ones : 0;
        c1_zeros = (c1_ones <= C1_BITS) ? C1_BITS - c1_ones : 0;
        thr = it.bad_chan ? THR_BCI : THR_NO_BCI;
        if (c1_zeros < C1_ZEROS_VALID) cls = SID_VALID;
        else if (sid_zeros < thr) cls = SID_INVALID;
        else cls = SID_SPEECH;
        // unvoiced frames never count as valid sid
        if (!frame_voiced && cls == SID_VALID) cls = SID_INVALID;
        res.sid_class = cls;
        res.bfi_upgrade = it.bad_chan && upgrade_en && sid_zeros >= UPG_LO
                          && sid_zeros <= UPG_HI;
        sid_results_q.push_back(res);
    endfunction

    // result checker and random output stall
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (sid_results_q.size() == 0) begin
                $error("unexpected result item: sid_class %0d bfi_upgrade %0d",
                       o_out_item.sid_class, o_out_item.bfi_upgrade);
                n_errors++;
            end else begin
                want = sid_results_q.pop_front();
                if (o_out_item.sid_class !== want.sid_class) begin
                    $error("sid_class: expected %0d, got %0d",
                           want.sid_class, o_out_item.sid_class);
                    n_errors++;
                end
                if (o_out_item.bfi_upgrade !== want.bfi_upgrade) begin
                    $error("bfi_upgrade: expected %0d, got %0d",
                           want.bfi_upgrade, o_out_item.bfi_upgrade);
                    n_errors++;
                end
            end
        end
        i_out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
    end

    // one byte item through the input handshake
    task automatic send_byte(input logic [7:0] b, input logic start, input logic bci);
        t_in_item it;
        it.frame_byte = b;
        it.frame_start = start;
        it.bad_chan = bci;
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        take_frame_byte(it);
        items_sent++;
    endtask

    // first len bytes of frame_buf, bci on the last one, random elsewhere
    task automatic send_frame(input int len, input logic start, input logic bci);
        for (int i = 0; i < len; i++) begin
            send_byte(frame_buf[i], (i == 0) ? start : 1'b0,
                      (i == len - 1) ? bci : 1'($urandom_range(1)));
        end
    endtask

    // frame content aimed at sid, near-sid and speech frames of either mode
    task automatic build_frame();
        int mix, n_clear, bit_idx;
        logic voiced;
        mix = $urandom_range(99);
        if (mix < 15) begin
            foreach (frame_buf[i]) frame_buf[i] = 8'($urandom);
        end else begin
            foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
            if (mix < 50) n_clear = $urandom_range(4);
            else if (mix < 85) n_clear = $urandom_range(30, 5);
            else n_clear = $urandom_range(111, 31);
            for (int k = 0; k < n_clear; k++) begin
                bit_idx = $urandom_range(FRAME_LEN * 8 - 1);
                frame_buf[bit_idx / 8][bit_idx % 8] = 1'b0;
            end
            voiced = 1'($urandom_range(1));
            if (!voiced) frame_buf[MODE_BYTE_POS][5:4] = 2'b00;
            else if (frame_buf[MODE_BYTE_POS][5:4] == 2'b00)
                frame_buf[MODE_BYTE_POS][4 + $urandom_range(1)] = 1'b1;
        end
    endtask

    // let every expected result come out, then settle
    task automatic wait_for_results();
        int n;
        i_in_valid <= 1'b0;
        n = 0;
        while (sid_results_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sid_results_q.size() != 0) begin
            $error("%0d result items never arrived", sid_results_q.size());
            n_errors++;
            sid_results_q.delete();
        end
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_UPGRADE_EN) upgrade_en = data[0];
        @(posedge i_clk);
    endtask

    task automatic check_upgrade_reg();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_UPGRADE_EN;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(upgrade_en)) begin
            $error("bfi_upgrade_enable: expected %0h, got %0h", 32'(upgrade_en), prdata);
            n_errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_register_reset();
        check_upgrade_reg();
    endtask

    task automatic test_directed_frames();
        // voiced frame of all ones: valid sid
        foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
        send_frame(FRAME_LEN, 1'b1, 1'b0);
        // partial frame of zeros, dropped by the restart that follows
        foreach (frame_buf[i]) frame_buf[i] = 8'h00;
        send_frame(2, 1'b1, 1'b1);
        // voiced with 20 sid zeros under bci: speech with the upgrade flag
        foreach (frame_buf[i]) frame_buf[i] = 8'hFF;
        frame_buf[5] = 8'h00;
        frame_buf[6] = 8'h00;
        frame_buf[7] = 8'h0F;
        send_frame(FRAME_LEN, 1'b1, 1'b1);
    endtask

    // mostly whole frames, some cut short, some loose bytes
    task automatic test_random_frames(input int gap_pct, input int stall_pct,
                                      input int n_items);
        int stop_at, kind, len;
        send_gap_pct = gap_pct;
        sink_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(99);
            build_frame();
            if (kind < 80) begin
                send_frame(FRAME_LEN, 1'($urandom_range(9) != 0), 1'($urandom_range(1)));
            end else if (kind < 90) begin
                send_frame($urandom_range(FRAME_LEN - 1, 1), 1'b1, 1'($urandom_range(1)));
            end else begin
                len = $urandom_range(6, 1);
                for (int i = 0; i < len; i++) begin
                    send_byte(8'($urandom), 1'($urandom_range(3) == 0),
                              1'($urandom_range(1)));
                end
            end
        end
        wait_for_results();
    endtask

    task automatic test_upgrade_disabled();
        // only bit 0 counts, upper bits random
        write_reg(ADDR_UPGRADE_EN, $urandom & ~32'h1);
        check_upgrade_reg();
        test_random_frames(57, 21, 580);
    endtask

    task automatic test_unused_address();
        write_reg(ADDR_UPGRADE_EN, $urandom | 32'h1);
        // a write outside the map leaves the enable alone
        write_reg(ADDR_UNMAPPED, 32'h0);
        check_upgrade_reg();
        test_random_frames(0, 0, 580);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item <= '0;
        i_out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        send_gap_pct = 21;
        sink_stall_pct = 57;
        test_directed_frames();
        test_random_frames(21, 57, 560);
        test_upgrade_disabled();
        test_unused_address();
        wait_for_results();

        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/hrsid_pkg.sv
rtl/core/hrsid_accum.sv
rtl/core/hrsid_decide.sv
rtl/core/gsm_hr_sid_frame_classifier_core.sv
test/tb_top.sv
